>>> sv/indexed_ordered_list_macros.svh
// ----------------------------------------------------------------------------
// Indexed ordered list assertion macros
// Shared concurrent assertion forms used by the checker.
// ----------------------------------------------------------------------------
`ifndef INDEXED_ORDERED_LIST_MACROS_SVH
`define INDEXED_ORDERED_LIST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define IOL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define IOL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/iol_pkg.sv
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Field widths, operation and status codes, defaults and shared types.
// ----------------------------------------------------------------------------
package iol_pkg;

    localparam int OPCODE_W = 2;
    localparam int POS_W    = 5;
    localparam int DATA_W   = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam int CAPACITY_DEF    = 16;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam logic [OPCODE_W-1:0] OP_INSERT = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_GET    = 2'd2;
    localparam logic [OPCODE_W-1:0] OP_SET    = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic execute;
    } ctl_cmd_t;

endpackage

>>> sv/iol_if.sv
// ----------------------------------------------------------------------------
// Indexed ordered list channels
// Valid/ready channels for operations and for results.
// ----------------------------------------------------------------------------
interface iol_in_if;
    logic                         valid;
    logic                         ready;
    logic [iol_pkg::OPCODE_W-1:0] opcode;
    logic [iol_pkg::POS_W-1:0]    position;
    logic [iol_pkg::DATA_W-1:0]   data_word;

    modport source (output valid, output opcode, output position, output data_word,
                    input ready);
    modport sink   (input valid, input opcode, input position, input data_word,
                    output ready);
endinterface

interface iol_out_if;
    logic                         valid;
    logic                         ready;
    logic [iol_pkg::DATA_W-1:0]   read_value;
    logic [iol_pkg::COUNT_W-1:0]  entry_count;
    logic [iol_pkg::STATUS_W-1:0] status;

    modport source (output valid, output read_value, output entry_count, output status,
                    input ready);
    modport sink   (input valid, input read_value, input entry_count, input status,
                    output ready);
endinterface

>>> sv/iol_ctrl.sv
// ----------------------------------------------------------------------------
// Indexed ordered list controller
// Sequences capture and execution of one operation and owns the result valid.
// ----------------------------------------------------------------------------
module iol_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    output logic              out_valid,
    input  logic              out_ready,
    output iol_pkg::ctl_cmd_t cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic state_reg;
    logic state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        in_ready    = (state_reg == S_IDLE);
        cmd.capture = (state_reg == S_IDLE) && in_valid;
        cmd.execute = (state_reg == S_EXEC) && (!out_valid_reg || out_ready);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (cmd.execute)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // The result slot fills on execution and drains on a result transfer.
    always_comb
    begin
        priority if (cmd.execute)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

>>> sv/iol_dp.sv
// ----------------------------------------------------------------------------
// Indexed ordered list datapath
// Row of shifting entry cells, entry count and the result register.
// ----------------------------------------------------------------------------
module iol_dp
#(
    parameter int CAPACITY    = iol_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  iol_pkg::ctl_cmd_t            cmd,
    input  logic [iol_pkg::OPCODE_W-1:0] opcode,
    input  logic [iol_pkg::POS_W-1:0]    position,
    input  logic [iol_pkg::DATA_W-1:0]   data_word,
    output logic [iol_pkg::DATA_W-1:0]   read_value,
    output logic [iol_pkg::COUNT_W-1:0]  entry_count,
    output logic [iol_pkg::STATUS_W-1:0] status
);

    localparam int CW   = $clog2(CAPACITY + 1);
    localparam int IDXW = $clog2(CAPACITY);
    localparam int PW   = ((CW > iol_pkg::POS_W) ? CW : iol_pkg::POS_W) + 1;

    logic [iol_pkg::OPCODE_W-1:0] op_reg;
    logic [iol_pkg::POS_W-1:0]    pos_reg;
    logic [VALUE_WIDTH-1:0]       word_reg;
    logic [CW-1:0]                count_reg;
    logic [CW-1:0]                count_next;
    logic [VALUE_WIDTH-1:0]       cells_reg [CAPACITY];
    logic [VALUE_WIDTH-1:0]       cells_next [CAPACITY];
    logic [iol_pkg::DATA_W-1:0]   rv_reg;
    logic [iol_pkg::DATA_W-1:0]   rv_next;
    logic [iol_pkg::COUNT_W-1:0]  cnt_out_reg;
    logic [iol_pkg::STATUS_W-1:0] st_reg;
    logic [iol_pkg::STATUS_W-1:0] st_next;

    logic [PW-1:0]          pos_x;
    logic [PW-1:0]          cnt_x;
    logic [VALUE_WIDTH-1:0] rd_word;
    logic                   ins_ok;
    logic                   rem_ok;
    logic                   set_ok;
    logic                   acc_ok;

    assign pos_x   = PW'(pos_reg);
    assign cnt_x   = PW'(count_reg);
    assign rd_word = cells_reg[IDXW'(pos_reg)];

    always_comb
    begin
        ins_ok  = 1'b0;
        acc_ok  = 1'b0;
        st_next = iol_pkg::ST_OK;
        if (op_reg == iol_pkg::OP_INSERT)
        begin
            priority if (pos_x > cnt_x)
            begin
                st_next = iol_pkg::ST_RANGE;
            end
            else if (cnt_x == PW'(CAPACITY))
            begin
                st_next = iol_pkg::ST_FULL;
            end
            else
            begin
                ins_ok = 1'b1;
            end
        end
        else if (pos_x >= cnt_x)
        begin
            st_next = iol_pkg::ST_RANGE;
        end
        else
        begin
            acc_ok = 1'b1;
        end
        rem_ok  = acc_ok && (op_reg == iol_pkg::OP_REMOVE);
        set_ok  = acc_ok && (op_reg == iol_pkg::OP_SET);
        rv_next = acc_ok ? iol_pkg::DATA_W'(rd_word) : '0;
    end

    always_comb
    begin
        priority if (ins_ok)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (rem_ok)
        begin
            count_next = count_reg - CW'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    // Each cell keeps its own value or takes the new word (insert or set at its
    // position), its lower neighbor (insert) or its upper neighbor (remove).
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [PW-1:0]          ix;
        logic [VALUE_WIDTH-1:0] below;
        logic [VALUE_WIDTH-1:0] above;

        assign ix = PW'(i);

        if (i > 0)
        begin : g_below
            assign below = cells_reg[i-1];
        end
        else
        begin : g_below_none
            assign below = cells_reg[i];
        end

        if (i < CAPACITY - 1)
        begin : g_above
            assign above = cells_reg[i+1];
        end
        else
        begin : g_above_none
            assign above = cells_reg[i];
        end

        always_comb
        begin
            cells_next[i] = cells_reg[i];
            priority if ((ins_ok || set_ok) && (ix == pos_x))
            begin
                cells_next[i] = word_reg;
            end
            else if (ins_ok && (ix > pos_x) && (ix <= cnt_x))
            begin
                cells_next[i] = below;
            end
            else if (rem_ok && (ix >= pos_x) && ((ix + PW'(1)) < cnt_x))
            begin
                cells_next[i] = above;
            end
            else
            begin
                cells_next[i] = cells_reg[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.execute)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg   <= opcode;
            pos_reg  <= position;
            word_reg <= VALUE_WIDTH'(data_word);
        end
        if (cmd.execute)
        begin
            cells_reg   <= cells_next;
            rv_reg      <= rv_next;
            cnt_out_reg <= iol_pkg::COUNT_W'(count_next);
            st_reg      <= st_next;
        end
    end

    assign read_value  = rv_reg;
    assign entry_count = cnt_out_reg;
    assign status      = st_reg;

endmodule

>>> sv/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// Indexed ordered list
// Fixed-capacity ordered list with insert, remove, get and set by position.
// ----------------------------------------------------------------------------
// Operations arrive on the cmd channel (opcode, position, data_word) and each
// one produces exactly one result on the rsp channel (read_value, entry_count,
// status). Both channels use a valid/ready handshake; a transfer happens at a
// rising edge with valid and ready both high.
// An operation is captured at the edge it is accepted and executed in the
// execute step once the result register is free; execution loads the
// result register, which presents the result until it transfers.
// The controller alternates capture and execute, so the block takes no new
// operation until the captured one has been executed.
// The result sits in an output register: the next operation is accepted and
// captured while an earlier result still waits. If the receiver stalls, the
// captured operation waits in the execute step until the result register is
// freed, and cmd.ready stays low meanwhile. No result is dropped or repeated.
// Insert and remove move all later entries at once through the row of
// shifting cells; errors leave the list untouched and return zero.
// Reset clears the entry count and the control state. Entry contents are not
// cleared; only written entries can ever be read, so no clearing pass runs.
// ----------------------------------------------------------------------------
module indexed_ordered_list
#(
    parameter int CAPACITY    = iol_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = iol_pkg::VALUE_WIDTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    iol_in_if.sink    cmd,
    iol_out_if.source rsp
);

    iol_pkg::ctl_cmd_t ctl_cmd;

    // Controller: decides when an operation is captured and executed.
    iol_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .cmd       (ctl_cmd)
    );

    // Datapath: entry cells, entry count and the registered result.
    iol_dp
    #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    )
    u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (ctl_cmd),
        .opcode      (cmd.opcode),
        .position    (cmd.position),
        .data_word   (cmd.data_word),
        .read_value  (rsp.read_value),
        .entry_count (rsp.entry_count),
        .status      (rsp.status)
    );

endmodule

>>> sv/iol_checker.sv
// ----------------------------------------------------------------------------
// Indexed ordered list checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "indexed_ordered_list_macros.svh"

module iol_checker
#(
    parameter int CAPACITY = iol_pkg::CAPACITY_DEF
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         rsp_valid,
    input logic                         rsp_ready,
    input logic [iol_pkg::DATA_W-1:0]   read_value,
    input logic [iol_pkg::COUNT_W-1:0]  entry_count,
    input logic [iol_pkg::STATUS_W-1:0] status
);

    `IOL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(read_value) && $stable(entry_count) && $stable(status), "result changed while stalled")
    `IOL_ASSERT_NOW(a_err_zero, rsp_valid && (status != iol_pkg::ST_OK), read_value == '0, "error result carries a nonzero value")
    `IOL_ASSERT_NOW(a_count_cap, rsp_valid, (CAPACITY > 31) || (int'(entry_count) <= CAPACITY), "entry count above capacity")
    `IOL_ASSERT_NOW(a_full_count, rsp_valid && (status == iol_pkg::ST_FULL), entry_count == iol_pkg::COUNT_W'(CAPACITY), "list full reported below capacity")

endmodule

bind indexed_ordered_list iol_checker #(.CAPACITY(CAPACITY)) u_iol_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .read_value  (rsp.read_value),
    .entry_count (rsp.entry_count),
    .status      (rsp.status)
);

>>> test/indexed_ordered_list_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Indexed ordered list testbench
// Drives list operations through the command channel, predicts each result
// from a local model of the list and checks every result transfer in order.
// ----------------------------------------------------------------------------
module indexed_ordered_list_test;

    localparam int LIST_CAP = iol_pkg::CAPACITY_DEF;

    // One list operation as it crosses the command channel.
    typedef struct {
        logic [iol_pkg::OPCODE_W-1:0] opcode;
        logic [iol_pkg::POS_W-1:0]    position;
        logic [iol_pkg::DATA_W-1:0]   data_word;
    } list_op_t;

    // One result as it crosses the response channel.
    typedef struct {
        logic [iol_pkg::DATA_W-1:0]   read_value;
        logic [iol_pkg::COUNT_W-1:0]  entry_count;
        logic [iol_pkg::STATUS_W-1:0] status;
    } list_result_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    iol_in_if  cmd_bus ();
    iol_out_if rsp_bus ();

    indexed_ordered_list dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    always #1 clk = ~clk;

    // Operations waiting to be driven, filled once by the stimulus block.
    list_op_t     pending_ops[$];
    // Results the list must still produce, oldest first.
    list_result_t awaited_results[$];

    // The list as the block should hold it after every accepted operation.
    logic [iol_pkg::DATA_W-1:0] model_words [LIST_CAP];
    int                         model_len = 0;

    // Length the list will have once all planned operations are applied;
    // used only to aim positions while building the stimulus.
    int planned_len = 0;

    int  ops_accepted   = 0;
    int  mismatch_count = 0;
    bit  cmd_taken      = 1'b0;

    // Idling is switched off for a long run in the middle of the test, so the
    // block also sees back-to-back traffic on both channels.
    wire steady = (ops_accepted >= 150) && (ops_accepted < 300);

    // All inputs of the block are known from time zero.
    initial
    begin
        cmd_bus.valid     = 1'b0;
        cmd_bus.opcode    = iol_pkg::OP_GET;
        cmd_bus.position  = '0;
        cmd_bus.data_word = '0;
        rsp_bus.ready     = 1'b0;
    end

    // Apply one operation to the local list and return the result it gives.
    // Error results leave the list alone and carry a zero value.
    function automatic list_result_t apply_list_op(input list_op_t op);
        list_result_t res;
        int           p;
        int           i;
        res.read_value = '0;
        res.status     = iol_pkg::ST_OK;
        p              = op.position;
        if (op.opcode == iol_pkg::OP_INSERT)
        begin
            // The range check comes first, so a far position on a full list
            // reports a range error rather than a full list.
            if (p > model_len)
                res.status = iol_pkg::ST_RANGE;
            else if (model_len >= LIST_CAP)
                res.status = iol_pkg::ST_FULL;
            else
            begin
                for (i = model_len; i > p; i--)
                    model_words[i] = model_words[i-1];
                model_words[p] = op.data_word;
                model_len++;
            end
        end
        else if (p >= model_len)
            res.status = iol_pkg::ST_RANGE;
        else
        begin
            res.read_value = model_words[p];
            if (op.opcode == iol_pkg::OP_REMOVE)
            begin
                for (i = p; i + 1 < model_len; i++)
                    model_words[i] = model_words[i+1];
                model_len--;
            end
            else if (op.opcode == iol_pkg::OP_SET)
                model_words[p] = op.data_word;
        end
        res.entry_count = model_len[iol_pkg::COUNT_W-1:0];
        return res;
    endfunction

    // Count a failure; only the first few are described in detail.
    function automatic void report_failure(input string what, input list_result_t want,
                                           input list_result_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display({"%0t: %s: expected value %h count %0d status %0d,",
                      " got value %h count %0d status %0d"},
                     $realtime, what, want.read_value, want.entry_count, want.status,
                     got.read_value, got.entry_count, got.status);
    endfunction

    // Queue an operation and track the length it leads to.
    task automatic plan_op(input logic [iol_pkg::OPCODE_W-1:0] opcode, input int position,
                           input logic [iol_pkg::DATA_W-1:0] word);
        list_op_t op;
        op.opcode    = opcode;
        op.position  = position[iol_pkg::POS_W-1:0];
        op.data_word = word;
        pending_ops.push_back(op);
        if (opcode == iol_pkg::OP_INSERT && position <= planned_len && planned_len < LIST_CAP)
            planned_len++;
        else if (opcode == iol_pkg::OP_REMOVE && position < planned_len)
            planned_len--;
    endtask

    // Monitor: at each rising edge, check a finished result transfer against
    // the oldest expectation, then predict the result of an accepted command.
    // The order matters only in principle; a command accepted at this edge
    // cannot have its result transferred at the same edge.
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n)
        begin
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got.read_value  = rsp_bus.read_value;
                got.entry_count = rsp_bus.entry_count;
                got.status      = rsp_bus.status;
                if (awaited_results.size() == 0)
                begin
                    want = '{default: '0};
                    report_failure("result with no operation pending", want, got);
                end
                else
                begin
                    want = awaited_results.pop_front();
                    if (got.read_value !== want.read_value ||
                        got.entry_count !== want.entry_count ||
                        got.status !== want.status)
                        report_failure("result mismatch", want, got);
                end
            end
            cmd_taken = cmd_bus.valid && cmd_bus.ready;
            if (cmd_taken)
            begin
                list_op_t op;
                op.opcode    = cmd_bus.opcode;
                op.position  = cmd_bus.position;
                op.data_word = cmd_bus.data_word;
                awaited_results.push_back(apply_list_op(op));
                ops_accepted++;
            end
        end
    end

    // Driver: at each falling edge, hold a command that has not been taken,
    // or else present the next pending one unless this cycle idles. The
    // receiver side stalls at random on the same rate.
    always @(negedge clk)
    begin
        list_op_t next_op;
        if (rst_n)
        begin
            rsp_bus.ready <= steady || ($urandom_range(99) >= 9);
            if (!cmd_bus.valid || cmd_taken)
            begin
                if (pending_ops.size() != 0 && (steady || $urandom_range(99) >= 9))
                begin
                    next_op = pending_ops.pop_front();
                    cmd_bus.valid     <= 1'b1;
                    cmd_bus.opcode    <= next_op.opcode;
                    cmd_bus.position  <= next_op.position;
                    cmd_bus.data_word <= next_op.data_word;
                end
                else
                    cmd_bus.valid <= 1'b0;
            end
        end
    end

    // Stimulus and end of run.
    initial
    begin
        bit growing;
        int pick;
        int pos;
        logic [iol_pkg::OPCODE_W-1:0] opc;

        // Directed part. Accesses on an empty list, an insert past the end
        // of an empty list, then filling and emptying a single entry.
        plan_op(iol_pkg::OP_GET, 0, $urandom());
        plan_op(iol_pkg::OP_REMOVE, 0, $urandom());
        plan_op(iol_pkg::OP_SET, 0, $urandom());
        plan_op(iol_pkg::OP_INSERT, 1, $urandom());
        plan_op(iol_pkg::OP_INSERT, 0, 32'hFFFF_FFFF);
        plan_op(iol_pkg::OP_REMOVE, 0, $urandom());
        // Fill the list to capacity at the front, at the end and in the middle,
        // with the all-zero and all-one words among the values.
        for (int k = 0; k < LIST_CAP; k++)
        begin
            if (k % 3 == 0)
                pos = 0;
            else if (k % 3 == 1)
                pos = planned_len;
            else
                pos = planned_len / 2;
            plan_op(iol_pkg::OP_INSERT, pos,
                    (k == 0) ? 32'h0 : (k == 1) ? 32'hFFFF_FFFF : $urandom());
        end
        // Append to a full list, then a position beyond the end of a full list,
        // which must report a range error, not a full list.
        plan_op(iol_pkg::OP_INSERT, LIST_CAP, $urandom());
        plan_op(iol_pkg::OP_INSERT, LIST_CAP + 1, $urandom());
        plan_op(iol_pkg::OP_GET, LIST_CAP - 1, $urandom());
        plan_op(iol_pkg::OP_SET, 0, 32'hFFFF_FFFF);
        plan_op(iol_pkg::OP_REMOVE, LIST_CAP - 1, $urandom());

        // Random part. The list drifts between empty and full so both ends
        // are visited often; most positions are in range, the rest anywhere
        // the position field can reach.
        growing = 1'b0;
        for (int n = 0; n < 423; n++)
        begin
            if ((planned_len == LIST_CAP && growing) || (planned_len == 0 && !growing))
            begin
                if ($urandom_range(3) == 0)
                    growing = !growing;
            end
            else if ($urandom_range(39) == 0)
                growing = !growing;

            pick = $urandom_range(99);
            if (pick < (growing ? 45 : 15))
                opc = iol_pkg::OP_INSERT;
            else if (pick < 60)
                opc = iol_pkg::OP_REMOVE;
            else if (pick < 80)
                opc = iol_pkg::OP_GET;
            else
                opc = iol_pkg::OP_SET;

            if ($urandom_range(99) < 12)
                pos = $urandom_range((1 << iol_pkg::POS_W) - 1);
            else if (opc == iol_pkg::OP_INSERT)
                pos = $urandom_range(planned_len);
            else
                pos = (planned_len == 0) ? 0 : $urandom_range(planned_len - 1);
            plan_op(opc, pos, $urandom());
        end

        // Reset is released at a falling edge so the driver starts cleanly.
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Wait for every command to be taken and every result to arrive, then
        // keep the clock running so that any stray result shows.
        while (pending_ops.size() != 0 || cmd_bus.valid)
            @(posedge clk);
        while (awaited_results.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);

        if (mismatch_count == 0)
            $display("indexed_ordered_list_test: clean");
        else
            $display("indexed_ordered_list_test: errors");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #400000;
        $display("indexed_ordered_list_test: errors");
        $finish;
    end

endmodule
